// ----- design/dss_pkg.sv -----
// Shared types and constants of the delimited span scanner.
// Holds the configuration bundle and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package dss_pkg;

  localparam int LIT_W = 64;
  localparam int LEN_W = 4;
  localparam int OUT_W = 16;

  localparam logic [7:0] CHAR_LF = 8'h0a;
  localparam logic [7:0] CHAR_CR = 8'h0d;

  // Lengths here are already clamped to the delimiter window depth.
  typedef struct packed {
    logic [LIT_W-1:0] start_literal;
    logic [LEN_W-1:0] start_len;
    logic [LIT_W-1:0] end_literal;
    logic [LEN_W-1:0] end_len;
    logic [LIT_W-1:0] esc_literal;
    logic [LEN_W-1:0] esc_len;
    logic             forbid_newline;
  } cfg_t;

  typedef struct packed {
    logic accept;   // a text byte is taken this cycle
    logic drain;    // one scan step on the window after the last byte
    logic finish;   // close the text and load the result register
  } cmd_t;

  typedef struct packed {
    logic drain_pending;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ----- design/dss_config.sv -----
// Configuration register file of the delimited span scanner.
// Decodes the plain write port and presents clamped lengths as dss_pkg::cfg_t.
`default_nettype none

module dss_config #(
  parameter int MAX_DELIM_BYTES = 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_write,
  input  wire logic [2:0]               cfg_index,
  input  wire logic [dss_pkg::LIT_W-1:0] cfg_data,
  output dss_pkg::cfg_t                 cfg
);

  localparam logic [2:0] REG_START_LITERAL  = 3'd0;
  localparam logic [2:0] REG_START_LENGTH   = 3'd1;
  localparam logic [2:0] REG_END_LITERAL    = 3'd2;
  localparam logic [2:0] REG_END_LENGTH     = 3'd3;
  localparam logic [2:0] REG_ESCAPE_LITERAL = 3'd4;
  localparam logic [2:0] REG_ESCAPE_LENGTH  = 3'd5;
  localparam logic [2:0] REG_FORBID_NEWLINE = 3'd6;

  localparam logic [dss_pkg::LEN_W-1:0] LEN_MAX = dss_pkg::LEN_W'(MAX_DELIM_BYTES);

  logic [dss_pkg::LIT_W-1:0] start_literal;
  logic [dss_pkg::LEN_W-1:0] start_length;
  logic [dss_pkg::LIT_W-1:0] end_literal;
  logic [dss_pkg::LEN_W-1:0] end_length;
  logic [dss_pkg::LIT_W-1:0] escape_literal;
  logic [dss_pkg::LEN_W-1:0] escape_length;
  logic                      forbid_newline;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_literal  <= '0;
      start_length   <= '0;
      end_literal    <= '0;
      end_length     <= '0;
      escape_literal <= '0;
      escape_length  <= '0;
      forbid_newline <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_START_LITERAL:  start_literal  <= cfg_data;
        REG_START_LENGTH:   start_length   <= cfg_data[dss_pkg::LEN_W-1:0];
        REG_END_LITERAL:    end_literal    <= cfg_data;
        REG_END_LENGTH:     end_length     <= cfg_data[dss_pkg::LEN_W-1:0];
        REG_ESCAPE_LITERAL: escape_literal <= cfg_data;
        REG_ESCAPE_LENGTH:  escape_length  <= cfg_data[dss_pkg::LEN_W-1:0];
        REG_FORBID_NEWLINE: forbid_newline <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.start_literal  = start_literal;
    cfg.start_len      = (start_length > LEN_MAX) ? LEN_MAX : start_length;
    cfg.end_literal    = end_literal;
    cfg.end_len        = (end_length > LEN_MAX) ? LEN_MAX : end_length;
    cfg.esc_literal    = escape_literal;
    cfg.esc_len        = (escape_length > LEN_MAX) ? LEN_MAX : escape_length;
    cfg.forbid_newline = forbid_newline;
  end

endmodule

`default_nettype wire

// ----- design/dss_ctrl.sv -----
// Controller of the delimited span scanner.
// Sequences byte intake, the window drain after the last beat and the result handoff.
// Depends on dss_pkg for the command and status structs.
`default_nettype none

module dss_ctrl (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire logic      in_last,
  output logic           in_ready,
  input  dss_pkg::status_t status,
  output dss_pkg::cmd_t  cmd
);

  typedef enum logic {
    ST_TAKE,
    ST_CLOSE
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_TAKE;
      in_ready <= 1'b0;
    end else begin
      unique case (state)
        ST_TAKE: begin
          if (in_valid && in_ready && in_last) begin
            state    <= ST_CLOSE;
            in_ready <= 1'b0;
          end else begin
            in_ready <= 1'b1;
          end
        end
        ST_CLOSE: begin
          if (!status.drain_pending && status.out_free) begin
            state    <= ST_TAKE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= ST_TAKE;
          in_ready <= 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    cmd.accept = (state == ST_TAKE) && in_valid && in_ready;
    cmd.drain  = (state == ST_CLOSE) && status.drain_pending;
    cmd.finish = (state == ST_CLOSE) && !status.drain_pending && status.out_free;
  end

endmodule

`default_nettype wire

// ----- design/dss_datapath.sv -----
// Datapath of the delimited span scanner: start literal check, lookahead window,
// one scan step per cycle, held span bounds and the result register.
// Depends on dss_pkg; driven by dss_ctrl commands.
`default_nettype none

module dss_datapath #(
  parameter int MAX_DELIM_BYTES = 8,
  parameter int POSITION_BITS   = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  dss_pkg::cfg_t                 cfg,
  input  dss_pkg::cmd_t                 cmd,
  output dss_pkg::status_t              status,
  input  wire logic [7:0]               in_byte,
  input  wire logic                     out_ready,
  output logic                          out_valid,
  output logic                          out_found,
  output logic [dss_pkg::OUT_W-1:0]     out_begin,
  output logic [dss_pkg::OUT_W-1:0]     out_finish,
  output logic [dss_pkg::OUT_W-1:0]     out_consumed
);

  localparam int WIN_W  = 8 * MAX_DELIM_BYTES;
  localparam int FILL_W = $clog2(MAX_DELIM_BYTES + 1);
  localparam int PB     = POSITION_BITS;
  localparam int LW     = dss_pkg::LEN_W;

  typedef enum logic [1:0] {
    PH_START,
    PH_SCAN,
    PH_DONE,
    PH_FAIL
  } phase_t;

  logic [WIN_W-1:0]  win, win_next;
  logic [FILL_W-1:0] fill, fill_next;
  logic [PB-1:0]     position, position_next;
  phase_t            phase, phase_next;
  logic [PB-1:0]     held_finish, held_finish_next;
  logic [PB-1:0]     held_consumed, held_consumed_next;
  logic              held_found, held_found_next;
  logic              too_long, too_long_next;

  logic          pos_full;
  logic [PB-1:0] pos_inc;
  logic          in_start_lit;
  logic [7:0]    start_byte;
  logic          push;
  logic          start_fail;
  logic          start_done;
  logic [WIN_W-1:0] pushed;

  // Scan step operands and results.
  logic [WIN_W-1:0]  sw;
  logic [FILL_W-1:0] sfill;
  logic [PB-1:0]     spos;
  logic              at_end;
  logic              step_en;
  logic [LW-1:0]     need;
  logic [7:0]        head;
  logic [PB-1:0]     off;
  logic              go;
  logic [MAX_DELIM_BYTES-1:0] x_ok, e_ok;
  logic              x_hit, e_hit;
  logic [WIN_W-1:0]  st_win;
  logic [FILL_W-1:0] st_fill;
  logic              st_settle, st_fail;
  logic [PB-1:0]     st_fin, st_con;

  logic          final_found;
  logic [PB-1:0] final_finish, final_consumed;

  assign pos_full     = (position == {PB{1'b1}});
  assign pos_inc      = position + 1'b1;
  assign in_start_lit = (position < PB'(cfg.start_len));
  assign start_byte   = cfg.start_literal[{position[2:0], 3'b000} +: 8];

  always_comb begin
    push       = 1'b0;
    start_fail = 1'b0;
    start_done = 1'b0;
    if (cmd.accept && !too_long && !pos_full) begin
      unique case (phase)
        PH_START: begin
          if (in_start_lit) begin
            if (in_byte != start_byte) begin
              start_fail = 1'b1;
            end else if (pos_inc == PB'(cfg.start_len)) begin
              start_done = 1'b1;
            end
          end else begin
            push = 1'b1;
          end
        end
        PH_SCAN: push = 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    pushed = win;
    for (int i = 0; i < MAX_DELIM_BYTES; i++) begin
      if (FILL_W'(i) == fill) begin
        pushed[8*i +: 8] = in_byte;
      end
    end
  end

  assign sw      = push ? pushed : win;
  assign sfill   = push ? (fill + 1'b1) : fill;
  assign spos    = push ? pos_inc : position;
  assign at_end  = cmd.drain;
  assign step_en = push || cmd.drain;

  // A step waits until the window holds the longer of the two literals,
  // except after the last beat, when the tail is scanned byte by byte.
  always_comb begin
    need = (cfg.end_len > cfg.esc_len) ? cfg.end_len : cfg.esc_len;
    if (need == '0) begin
      need = LW'(1);
    end
  end

  assign head = sw[7:0];
  assign off  = spos - PB'(sfill);
  assign go   = (sfill != '0) && (at_end || (LW'(sfill) >= need));

  always_comb begin
    for (int i = 0; i < MAX_DELIM_BYTES; i++) begin
      x_ok[i] = (sw[8*i +: 8] == cfg.esc_literal[8*i +: 8]) || (LW'(i) >= cfg.esc_len);
      e_ok[i] = (sw[8*i +: 8] == cfg.end_literal[8*i +: 8]) || (LW'(i) >= cfg.end_len);
    end
  end

  assign x_hit = (cfg.esc_len != '0) && (LW'(sfill) >= cfg.esc_len) && (&x_ok);
  assign e_hit = (cfg.end_len != '0) && (LW'(sfill) >= cfg.end_len) && (&e_ok);

  always_comb begin
    st_win    = sw;
    st_fill   = sfill;
    st_settle = 1'b0;
    st_fail   = 1'b0;
    st_fin    = off;
    st_con    = off;
    if (go) begin
      if ((cfg.end_len == '0) && (head == dss_pkg::CHAR_LF || head == dss_pkg::CHAR_CR)) begin
        st_settle = 1'b1;
      end else if (cfg.forbid_newline && head == dss_pkg::CHAR_LF) begin
        st_fail = 1'b1;
      end else if (x_hit) begin
        st_win  = sw >> {cfg.esc_len, 3'b000};
        st_fill = sfill - FILL_W'(cfg.esc_len);
      end else if (e_hit) begin
        st_settle = 1'b1;
        st_con    = off + PB'(cfg.end_len);
      end else begin
        st_win  = sw >> 8;
        st_fill = sfill - 1'b1;
      end
    end
  end

  // An open span at the end of the text closes there only without an end literal.
  assign final_found    = !too_long &&
                          (held_found || (phase == PH_SCAN && cfg.end_len == '0));
  assign final_finish   = held_found ? held_finish : position;
  assign final_consumed = held_found ? held_consumed : position;

  always_comb begin
    win_next           = win;
    fill_next          = fill;
    position_next      = position;
    phase_next         = phase;
    held_finish_next   = held_finish;
    held_consumed_next = held_consumed;
    held_found_next    = held_found;
    too_long_next      = too_long;
    if (cmd.finish) begin
      fill_next          = '0;
      position_next      = '0;
      phase_next         = PH_START;
      held_finish_next   = '0;
      held_consumed_next = '0;
      held_found_next    = 1'b0;
      too_long_next      = 1'b0;
    end else begin
      if (cmd.accept) begin
        if (too_long || pos_full) begin
          too_long_next = 1'b1;
        end else begin
          position_next = pos_inc;
        end
        if (start_fail) begin
          phase_next = PH_FAIL;
        end else if (start_done || push) begin
          phase_next = PH_SCAN;
        end
      end
      if (step_en) begin
        win_next  = st_win;
        fill_next = st_fill;
        if (st_settle) begin
          held_finish_next   = st_fin;
          held_consumed_next = st_con;
          held_found_next    = 1'b1;
          phase_next         = PH_DONE;
        end else if (st_fail) begin
          phase_next = PH_FAIL;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    win           <= win_next;
    held_finish   <= held_finish_next;
    held_consumed <= held_consumed_next;
    if (rst) begin
      fill       <= '0;
      position   <= '0;
      phase      <= PH_START;
      held_found <= 1'b0;
      too_long   <= 1'b0;
    end else begin
      fill       <= fill_next;
      position   <= position_next;
      phase      <= phase_next;
      held_found <= held_found_next;
      too_long   <= too_long_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_found    <= final_found;
      out_begin    <= final_found ? dss_pkg::OUT_W'(cfg.start_len) : '0;
      out_finish   <= final_found ? dss_pkg::OUT_W'(final_finish) : '0;
      out_consumed <= final_found ? dss_pkg::OUT_W'(final_consumed) : '0;
    end
  end

  assign status.drain_pending = !too_long && (phase == PH_SCAN) && (fill != '0);
  assign status.out_free      = !out_valid || out_ready;

`ifndef ASSERT_OFF
  a_finish_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || out_ready))
    else $error("result loaded while the previous result was still held");

  a_held_means_done: assert property (@(posedge clk) disable iff (rst)
    held_found |-> (phase == PH_DONE))
    else $error("span bounds held while the scan is not settled");

  a_drain_only_open_window: assert property (@(posedge clk) disable iff (rst)
    cmd.drain |-> ((phase == PH_SCAN) && (fill != '0) && !too_long))
    else $error("drain step issued with nothing left to scan");

  a_commands_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.accept, cmd.drain, cmd.finish}))
    else $error("more than one datapath command in a cycle");

  a_finish_clears_text: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (out_valid && (position == '0) && (fill == '0)))
    else $error("text state not cleared after the result was loaded");
`endif

endmodule

`default_nettype wire

// ----- design/delimited_span_scanner_unit.sv -----
// Top level of the delimited span scanner: stream ports, configuration port,
// and the wiring of dss_config, dss_ctrl and dss_datapath (all using dss_pkg).
`default_nettype none

// A token text streams in one byte per beat, the final byte flagged by s_tlast.
// Within a text every byte is accepted as it arrives, as the scan keeps pace
// with the lookahead window. After the last beat the scanner steps through what
// is left in the window, one step per cycle, and then loads the result register.
// s_tready stays low during that close-out and right after reset; the close-out
// also waits while the previous result still sits in the output register.
// Exactly one result beat comes out per text: found in m_tuser, span offsets in
// m_tdata, all offsets zero when nothing was found.
// Configuration must be written only between texts.
module delimited_span_scanner_unit #(
  parameter int MAX_DELIM_BYTES = 8,
  parameter int POSITION_BITS   = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // text_byte [7:0]
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // content_begin [15:0], content_finish [31:16],
                                      // consumed_length [47:32]
  output logic             m_tuser    // found [0]
);

  dss_pkg::cfg_t    cfg;
  dss_pkg::cmd_t    cmd;
  dss_pkg::status_t status;

  logic [dss_pkg::OUT_W-1:0] content_begin;
  logic [dss_pkg::OUT_W-1:0] content_finish;
  logic [dss_pkg::OUT_W-1:0] consumed_length;

  dss_config #(
    .MAX_DELIM_BYTES(MAX_DELIM_BYTES)
  ) u_config (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  dss_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_last (s_tlast),
    .in_ready(s_tready),
    .status  (status),
    .cmd     (cmd)
  );

  dss_datapath #(
    .MAX_DELIM_BYTES(MAX_DELIM_BYTES),
    .POSITION_BITS  (POSITION_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .status      (status),
    .in_byte     (s_tdata),
    .out_ready   (m_tready),
    .out_valid   (m_tvalid),
    .out_found   (m_tuser),
    .out_begin   (content_begin),
    .out_finish  (content_finish),
    .out_consumed(consumed_length)
  );

  assign m_tdata = {consumed_length, content_finish, content_begin};

endmodule

`default_nettype wire

// ----- tb/sv/dss_span_checker.sv -----
// Register index names shared by the testbench files, and the span checker.
// The checker mirrors configuration writes, predicts one result per text and
// compares it with the result channel. Depends on dss_pkg.
package dss_tb_pkg;

  typedef enum logic [2:0] {
    REG_START_LITERAL  = 3'd0,
    REG_START_LENGTH   = 3'd1,
    REG_END_LITERAL    = 3'd2,
    REG_END_LENGTH     = 3'd3,
    REG_ESCAPE_LITERAL = 3'd4,
    REG_ESCAPE_LENGTH  = 3'd5,
    REG_FORBID_NEWLINE = 3'd6,
    REG_NONE           = 3'd7
  } reg_index_t;

endpackage

module dss_span_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // text_byte [7:0]
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,   // content_begin [15:0], content_finish [31:16],
                                 // consumed_length [47:32]
  input  logic        m_tuser,   // found [0]
  output int          fail_count,
  output int          open_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW_DEPTH = 8;
  localparam int unsigned LAST_POSITION = 65535;

  typedef enum logic [1:0] {
    SCAN_START,
    SCAN_BODY,
    SCAN_DONE,
    SCAN_FAIL
  } scan_phase_t;

  typedef struct {
    logic        found;
    logic [15:0] content_begin;
    logic [15:0] content_finish;
    logic [15:0] consumed_length;
  } span_result_t;

  // Mirrored configuration.
  logic [63:0] start_lit, end_lit, esc_lit;
  logic [3:0]  start_len, end_len, esc_len;
  logic        forbid_nl;

  // Per-text scan state.
  logic [7:0]  win [WINDOW_DEPTH];
  int unsigned fill;
  int unsigned pos;
  scan_phase_t phase;
  int unsigned held_fin, held_con;
  logic        held_found;
  logic        too_long;

  span_result_t pending_spans [$];
  int errors = 0;

  assign fail_count = errors;

  function automatic int unsigned sat_len(logic [3:0] n);
    return (n > WINDOW_DEPTH) ? WINDOW_DEPTH : int'(n);
  endfunction

  function automatic void clear_text();
    for (int i = 0; i < WINDOW_DEPTH; i++) win[i] = 8'h00;
    fill = 0;
    pos = 0;
    phase = SCAN_START;
    held_fin = 0;
    held_con = 0;
    held_found = 1'b0;
    too_long = 1'b0;
  endfunction

  function automatic logic window_holds(logic [63:0] lit, int unsigned n);
    for (int i = 0; i < n; i++)
      if (win[i] != lit[8*i +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void shift_out(int unsigned n);
    int unsigned k;
    k = (n > fill) ? fill : n;
    for (int i = 0; i + k < WINDOW_DEPTH; i++) win[i] = win[i + k];
    fill -= k;
  endfunction

  function automatic void close_span(int unsigned fin, int unsigned con);
    held_fin = fin;
    held_con = con;
    held_found = 1'b1;
    phase = SCAN_DONE;
  endfunction

  function automatic void take_byte(logic [7:0] b);
    if (fill < WINDOW_DEPTH) begin
      win[fill] = b;
      fill++;
    end
  endfunction

  // Resolve the head of the window as far as the buffered bytes allow; at the
  // end of the text everything left is resolved.
  function automatic void walk_window(logic at_end);
    int unsigned el, xl, need, off;
    el = sat_len(end_len);
    xl = sat_len(esc_len);
    need = (el > xl) ? el : xl;
    if (need == 0) need = 1;
    while (phase == SCAN_BODY && fill > 0 && (at_end || fill >= need)) begin
      off = pos - fill;
      if (el == 0 && (win[0] == dss_pkg::CHAR_LF || win[0] == dss_pkg::CHAR_CR)) begin
        close_span(off, off);
      end else if (forbid_nl && win[0] == dss_pkg::CHAR_LF) begin
        phase = SCAN_FAIL;
      end else if (xl != 0 && fill >= xl && window_holds(esc_lit, xl)) begin
        shift_out(xl);
      end else if (el != 0 && fill >= el && window_holds(end_lit, el)) begin
        close_span(off, off + el);
      end else begin
        shift_out(1);
      end
    end
    if (at_end && phase == SCAN_BODY) begin
      if (el == 0) close_span(pos, pos);
      else phase = SCAN_FAIL;
    end
  endfunction

  function automatic void absorb_byte(logic [7:0] b, logic last);
    int unsigned slen, off;
    slen = sat_len(start_len);
    if (!too_long) begin
      if (pos >= LAST_POSITION) too_long = 1'b1;
      else pos++;
    end
    if (!too_long) begin
      off = pos - 1;
      if (phase == SCAN_START) begin
        if (off < slen) begin
          if (b != start_lit[8*off +: 8]) phase = SCAN_FAIL;
          else if (off + 1 == slen) phase = SCAN_BODY;
        end else begin
          phase = SCAN_BODY;
          take_byte(b);
          walk_window(1'b0);
        end
      end else if (phase == SCAN_BODY) begin
        take_byte(b);
        walk_window(1'b0);
      end
      if (last && phase == SCAN_BODY) walk_window(1'b1);
    end
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : watch
    span_result_t want;
    if (rst) begin
      start_lit = '0;
      end_lit = '0;
      esc_lit = '0;
      start_len = '0;
      end_len = '0;
      esc_len = '0;
      forbid_nl = 1'b0;
      clear_text();
      pending_spans.delete();
    end else begin
      // Results are checked first so that a text closing on this edge is
      // never matched against its own result.
      if (m_tvalid && m_tready) begin
        if (pending_spans.size() == 0) begin
          $error("result beat with no text outstanding");
          errors++;
        end else begin
          want = pending_spans.pop_front();
          check_field("found", 16'(want.found), 16'(m_tuser));
          check_field("content_begin", want.content_begin, m_tdata[15:0]);
          check_field("content_finish", want.content_finish, m_tdata[31:16]);
          check_field("consumed_length", want.consumed_length, m_tdata[47:32]);
        end
      end
      if (cfg_write) begin
        case (dss_tb_pkg::reg_index_t'(cfg_index))
          dss_tb_pkg::REG_START_LITERAL:  start_lit = cfg_data;
          dss_tb_pkg::REG_START_LENGTH:   start_len = cfg_data[3:0];
          dss_tb_pkg::REG_END_LITERAL:    end_lit = cfg_data;
          dss_tb_pkg::REG_END_LENGTH:     end_len = cfg_data[3:0];
          dss_tb_pkg::REG_ESCAPE_LITERAL: esc_lit = cfg_data;
          dss_tb_pkg::REG_ESCAPE_LENGTH:  esc_len = cfg_data[3:0];
          dss_tb_pkg::REG_FORBID_NEWLINE: forbid_nl = cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        absorb_byte(s_tdata, s_tlast);
        if (s_tlast) begin
          want.found = !too_long && held_found;
          if (want.found) begin
            want.content_begin = 16'(sat_len(start_len));
            want.content_finish = held_fin[15:0];
            want.consumed_length = held_con[15:0];
          end else begin
            want.content_begin = '0;
            want.content_finish = '0;
            want.consumed_length = '0;
          end
          pending_spans.push_back(want);
          clear_text();
        end
      end
    end
    open_count <= pending_spans.size();
  end

endmodule

// ----- tb/sv/tb_delimited_span_scanner_unit.sv -----
// Testbench top of the delimited span scanner: clock, reset, configuration
// phases, text stimulus with random idling on both sides, and the verdict.
// Depends on dss_pkg, dss_tb_pkg and dss_span_checker.
module tb_delimited_span_scanner_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD     = 1;
  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int SETTLE_CYCLES   = 12;
  localparam int RANDOM_PHASES   = 10;
  localparam int BYTES_PER_PHASE = 60;

  typedef struct {
    logic [63:0] start_lit;
    logic [3:0]  start_len;
    logic [63:0] end_lit;
    logic [3:0]  end_len;
    logic [63:0] esc_lit;
    logic [3:0]  esc_len;
    logic        forbid_nl;
  } span_cfg_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tuser;
  int          fail_count;
  int          open_count;

  span_cfg_t   cfg;
  logic [7:0]  text_q [$];
  int          tx_odds = 0;
  int          rx_odds = 0;
  int          rx_hold = 0;
  int          quiet_cycles = 0;

  delimited_span_scanner_unit u_top (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  dss_span_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .fail_count(fail_count), .open_count(open_count)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Result side: stalls come in bursts of random length.
  always @(posedge clk) begin
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      m_tready <= 1'b0;
    end else if (rx_odds != 0 && $urandom_range(rx_odds - 1, 0) == 0) begin
      rx_hold <= $urandom_range(14, 0);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_write)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] lit_of(string s);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < s.len() && i < 8; i++) v[8*i +: 8] = s[i];
    return v;
  endfunction

  function automatic int clamp8(logic [3:0] n);
    return (n > 8) ? 8 : int'(n);
  endfunction

  function automatic logic [7:0] delim_char();
    case ($urandom_range(7, 0))
      0: return "\"";
      1: return "'";
      2: return "\\";
      3: return "*";
      4: return "/";
      5: return "#";
      default: return 8'($urandom_range(255, 0));
    endcase
  endfunction

  function automatic logic [7:0] filler_byte();
    case ($urandom_range(9, 0))
      0: return 8'($urandom_range(255, 0));
      1: return delim_char();
      default: return 8'("a" + $urandom_range(25, 0));
    endcase
  endfunction

  function automatic logic [3:0] draw_len();
    int r;
    r = $urandom_range(19, 0);
    if (r <= 3) return 4'd0;
    if (r <= 13) return 4'($urandom_range(3, 1));
    if (r <= 17) return 4'($urandom_range(8, 4));
    return 4'($urandom_range(15, 9));
  endfunction

  function automatic logic [63:0] draw_literal();
    logic [63:0] v;
    for (int i = 0; i < 8; i++) v[8*i +: 8] = delim_char();
    return v;
  endfunction

  task automatic write_reg(dss_tb_pkg::reg_index_t idx, logic [63:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  // Length and flag writes carry random upper bits, which the block ignores.
  task automatic program_regs();
    logic [63:0] pad;
    pad = {$urandom(), $urandom()};
    write_reg(dss_tb_pkg::REG_START_LITERAL, cfg.start_lit);
    write_reg(dss_tb_pkg::REG_START_LENGTH, {pad[63:4], cfg.start_len});
    write_reg(dss_tb_pkg::REG_END_LITERAL, cfg.end_lit);
    write_reg(dss_tb_pkg::REG_END_LENGTH, {pad[63:4], cfg.end_len});
    write_reg(dss_tb_pkg::REG_ESCAPE_LITERAL, cfg.esc_lit);
    write_reg(dss_tb_pkg::REG_ESCAPE_LENGTH, {pad[63:4], cfg.esc_len});
    write_reg(dss_tb_pkg::REG_FORBID_NEWLINE, {pad[63:1], cfg.forbid_nl});
    write_reg(dss_tb_pkg::REG_NONE, ~pad);
    cfg_write <= 1'b0;
  endtask

  task automatic set_cfg(string open_s, string close_s, string esc_s, logic forbid);
    cfg.start_lit = lit_of(open_s);
    cfg.start_len = 4'(open_s.len());
    cfg.end_lit = lit_of(close_s);
    cfg.end_len = 4'(close_s.len());
    cfg.esc_lit = lit_of(esc_s);
    cfg.esc_len = 4'(esc_s.len());
    cfg.forbid_nl = forbid;
    program_regs();
  endtask

  task automatic send_beat(logic [7:0] b, logic last);
    if (tx_odds != 0 && $urandom_range(tx_odds - 1, 0) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(15, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_beat(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic send_str(string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    send_text();
  endtask

  // Stop sending and wait until every text has given its result.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_lit(logic [63:0] lit, int n);
    for (int k = 0; k < n; k++) text_q.push_back(lit[8*k +: 8]);
  endtask

  // Mostly well-formed texts: start literal, content mixing escapes, partial
  // delimiters and line breaks, the end literal, then trailing bytes.
  task automatic build_text();
    int sl, el, xl, n;
    sl = clamp8(cfg.start_len);
    el = clamp8(cfg.end_len);
    xl = clamp8(cfg.esc_len);
    text_q.delete();
    if ($urandom_range(9, 0) == 0) begin
      repeat ($urandom_range(12, 1)) text_q.push_back(8'($urandom_range(255, 0)));
    end else begin
      push_lit(cfg.start_lit, sl);
      if (sl != 0 && $urandom_range(11, 0) == 0) begin
        n = $urandom_range(sl - 1, 0);
        text_q[n] = text_q[n] ^ 8'(1 << $urandom_range(7, 0));
      end
      if (sl != 0 && $urandom_range(15, 0) == 0) void'(text_q.pop_back());
      repeat ($urandom_range(8, 0)) begin
        case ($urandom_range(11, 0))
          0, 1, 2, 3: text_q.push_back(filler_byte());
          4, 5: push_lit(cfg.esc_lit, xl);
          6: begin
            n = (xl > 1) ? $urandom_range(xl - 1, 1) : 0;
            push_lit(cfg.esc_lit, n);
          end
          7: begin
            n = (el > 1) ? $urandom_range(el - 1, 1) : 0;
            push_lit(cfg.end_lit, n);
          end
          8: text_q.push_back($urandom_range(1, 0) ? dss_pkg::CHAR_LF : dss_pkg::CHAR_CR);
          9: push_lit(cfg.end_lit, el);
          default: text_q.push_back(8'($urandom_range(255, 0)));
        endcase
      end
      if ($urandom_range(3, 0) != 0) push_lit(cfg.end_lit, el);
      repeat ($urandom_range(3, 0)) text_q.push_back(filler_byte());
    end
    if (text_q.size() == 0) text_q.push_back(filler_byte());
  endtask

  initial begin
    int sent;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Registers still at reset: no start literal, spans end at CR, LF or end.
    tx_odds = 4;
    rx_odds <= 3;
    text_q = {8'h00};
    send_text();
    text_q = {8'hff, dss_pkg::CHAR_CR, 8'h41};
    send_text();
    send_str("ab\ncd");
    drain_results();

    // Quoted string with an escaped quote; a line feed inside fails.
    set_cfg("\"", "\"", "\\\"", 1'b1);
    send_str("\"abc\"");
    send_str("\"a\\\"b\"x");
    send_str("\"ab\ncd\"");
    send_str("x\"a\"");
    send_str("\"abc");
    drain_results();

    // Block comment: a partial closing delimiter at the end does not match.
    set_cfg("/*", "*/", "", 1'b0);
    send_str("/*ab*");
    send_str("/");
    send_str("/*a\nb*/junk");
    drain_results();

    // Line comment: the line break wins over the newline restriction.
    set_cfg("#", "", "", 1'b1);
    send_str("#ab\rcd");
    send_str("#ab\n");
    send_str("#abc");
    drain_results();

    // Lengths beyond the window depth saturate to eight bytes.
    cfg.start_lit = '1;
    cfg.start_len = 4'd15;
    cfg.end_lit = lit_of("ENDMARK!");
    cfg.end_len = 4'd15;
    cfg.esc_lit = '0;
    cfg.esc_len = 4'd15;
    cfg.forbid_nl = 1'b1;
    program_regs();
    text_q.delete();
    push_lit(cfg.start_lit, 8);
    push_lit(cfg.esc_lit, 8);
    text_q.push_back("q");
    push_lit(cfg.end_lit, 8);
    text_q.push_back("z");
    send_text();
    text_q.delete();
    push_lit(cfg.start_lit, 8);
    text_q.push_back("a");
    push_lit(cfg.end_lit, 7);
    send_text();
    text_q.delete();
    push_lit(cfg.start_lit, 7);
    send_text();
    drain_results();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      cfg.start_lit = draw_literal();
      cfg.start_len = draw_len();
      cfg.end_lit = draw_literal();
      cfg.end_len = draw_len();
      cfg.esc_lit = draw_literal();
      cfg.esc_len = draw_len();
      cfg.forbid_nl = 1'($urandom_range(1, 0));
      program_regs();
      if (ph >= RANDOM_PHASES - 2) begin
        tx_odds = 0;
        rx_odds <= 0;
      end else begin
        tx_odds = $urandom_range(2, 0) * 4;
        rx_odds <= $urandom_range(2, 0) * 4;
      end
      sent = 0;
      while (sent < BYTES_PER_PHASE) begin
        build_text();
        sent += text_q.size();
        send_text();
      end
      drain_results();
    end

    if (fail_count == 0 && open_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
